// ----- design/spl_pkg.sv -----
// spl_pkg: shared constants, request and status codes, and the command and
// status structs that join the controller and the datapath of the sorted list.
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package spl_pkg;

	localparam int DEPTH_DEF      = 32;
	localparam int VALUE_BITS_DEF = 32;

	// request codes
	localparam logic [1:0] REQ_INSERT = 2'd0;
	localparam logic [1:0] REQ_REMOVE = 2'd1;
	localparam logic [1:0] REQ_READ   = 2'd2;

	// result status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;
	localparam logic [1:0] ST_RANGE = 2'd3;

	// controller to datapath
	typedef struct packed {
		logic lat_req;   // capture the incoming item
		logic lat_st;    // capture the status code of the held item
		logic rd_tail;   // read the last entry and drop it from the count
		logic rd_idx;    // read the entry at the requested position
		logic j_init;    // start the insert pointer at the count
		logic rd_below;  // read the entry just below the insert pointer
		logic shift;     // move the entry just read up by one, step pointer down
		logic put;       // write the new value at the pointer, grow the count
		logic out_ld;    // load the result register
	} spl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [1:0] req_type;
		logic       full;
		logic       empty;
		logic       idx_oob;
		logic       j_zero;
		logic       greater;  // entry read is greater than the new value
	} spl_stat_t;

endpackage

`default_nettype wire

// ----- design/spl_dp.sv -----
// spl_dp: datapath of the sorted list: entry memory, fill count, insert
// pointer, held item and result registers. Uses spl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module spl_dp
	import spl_pkg::*;
#(
	parameter int DEPTH      = DEPTH_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF,
	parameter int AW         = $clog2(DEPTH),
	parameter int CW         = $clog2(DEPTH + 1)
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire spl_cmd_t             cmd,
	output spl_stat_t                 stat,
	input  wire logic [1:0]           req_type,
	input  wire logic signed [31:0]   value,
	input  wire logic [AW-1:0]        index,
	output logic [1:0]                status,
	output logic signed [31:0]        data_out,
	output logic [CW-1:0]             count
);

	logic [VALUE_BITS-1:0] mem [DEPTH];
	logic [VALUE_BITS-1:0] rd_q;
	logic [VALUE_BITS-1:0] val_q;
	logic [1:0]            type_q;
	logic [AW-1:0]         idx_q;
	logic [AW-1:0]         j_q;
	logic [CW-1:0]         count_q;
	logic [1:0]            st_q;
	logic [1:0]            status_q;
	logic signed [31:0]    data_q;
	logic [CW-1:0]         cnt_q;

	logic [AW-1:0]          rd_addr;
	logic                   rd_en;
	logic [AW-1:0]          wr_addr;
	logic [VALUE_BITS-1:0]  wr_data;
	logic                   wr_en;
	logic signed [63:0]     val_ext;
	logic signed [VALUE_BITS-1:0] rd_signed;
	logic signed [63:0]     rd_ext;
	logic [1:0]             st_now;
	logic signed [31:0]     data_sel;

	assign val_ext   = 64'(value);
	assign rd_signed = rd_q;
	assign rd_ext    = 64'(rd_signed);

	assign stat.req_type = type_q;
	assign stat.full     = (count_q == CW'(DEPTH));
	assign stat.empty    = (count_q == '0);
	assign stat.idx_oob  = (CW'(idx_q) >= count_q);
	assign stat.j_zero   = (j_q == '0);
	assign stat.greater  = ($signed(rd_q) > $signed(val_q));

	always_comb begin
		rd_en   = cmd.rd_tail | cmd.rd_idx | cmd.rd_below;
		rd_addr = j_q - AW'(1);
		if (cmd.rd_tail) begin
			rd_addr = AW'(count_q - CW'(1));
		end else if (cmd.rd_idx) begin
			rd_addr = idx_q;
		end
		wr_en   = cmd.shift | cmd.put;
		wr_addr = j_q;
		wr_data = cmd.shift ? rd_q : val_q;
	end

	always_comb begin
		case (type_q)
			REQ_INSERT: st_now = stat.full ? ST_FULL : ST_OK;
			REQ_REMOVE: st_now = stat.empty ? ST_EMPTY : ST_OK;
			REQ_READ:   st_now = stat.idx_oob ? ST_RANGE : ST_OK;
			default:    st_now = ST_OK;
		endcase
	end

	always_comb begin
		data_sel = '0;
		if (st_q == ST_OK && (type_q == REQ_REMOVE || type_q == REQ_READ)) begin
			data_sel = rd_ext[31:0];
		end
	end

	// entry store, registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// held item and result payload
	always_ff @(posedge clk) begin
		if (cmd.lat_req) begin
			type_q <= req_type;
			val_q  <= val_ext[VALUE_BITS-1:0];
			idx_q  <= index;
		end
		if (cmd.lat_st) begin
			st_q <= st_now;
		end
		if (cmd.out_ld) begin
			status_q <= st_q;
			data_q   <= data_sel;
			cnt_q    <= count_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			j_q     <= '0;
		end else begin
			if (cmd.rd_tail) begin
				count_q <= count_q - CW'(1);
			end else if (cmd.put) begin
				count_q <= count_q + CW'(1);
			end
			if (cmd.j_init) begin
				j_q <= AW'(count_q);
			end else if (cmd.shift) begin
				j_q <= j_q - AW'(1);
			end
		end
	end

	assign status   = status_q;
	assign data_out = data_q;
	assign count    = cnt_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("fill count above depth");

	a_put_grows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.put |=> count_q == $past(count_q) + CW'(1))
		else $error("insert did not grow the count");

	a_shift_ok: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.shift |-> (!stat.j_zero && stat.greater))
		else $error("shift without a greater entry below the pointer");

	a_tail_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_tail |-> !stat.empty)
		else $error("remove issued on an empty list");

endmodule

`default_nettype wire

// ----- design/spl_ctrl.sv -----
// spl_ctrl: controller state machine of the sorted list; sequences each item
// and drives the handshakes. Uses spl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module spl_ctrl
	import spl_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      req_valid,
	output logic           req_stall,
	output logic           rsp_valid,
	input  wire logic      rsp_stall,
	input  wire spl_stat_t stat,
	output spl_cmd_t       cmd
);

	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_DEC     = 3'd1;
	localparam logic [2:0] S_INS_RD  = 3'd2;
	localparam logic [2:0] S_INS_CMP = 3'd3;
	localparam logic [2:0] S_INS_WR  = 3'd4;
	localparam logic [2:0] S_RESP    = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       rsp_valid_q;
	logic       out_free;

	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.lat_req = 1'b1;
					state_d     = S_DEC;
				end
			end
			S_DEC: begin
				cmd.lat_st = 1'b1;
				state_d    = S_RESP;
				case (stat.req_type)
					REQ_INSERT: begin
						if (!stat.full) begin
							cmd.j_init = 1'b1;
							state_d    = S_INS_RD;
						end
					end
					REQ_REMOVE: cmd.rd_tail = !stat.empty;
					REQ_READ:   cmd.rd_idx  = !stat.idx_oob;
					default: ;
				endcase
			end
			S_INS_RD: begin
				if (stat.j_zero) begin
					state_d = S_INS_WR;
				end else begin
					cmd.rd_below = 1'b1;
					state_d      = S_INS_CMP;
				end
			end
			S_INS_CMP: begin
				if (stat.greater) begin
					cmd.shift = 1'b1;
					state_d   = S_INS_RD;
				end else begin
					state_d = S_INS_WR;
				end
			end
			S_INS_WR: begin
				cmd.put = 1'b1;
				state_d = S_RESP;
			end
			S_RESP: begin
				if (out_free) begin
					cmd.out_ld = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_ld) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	a_cmp_after_rd: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_INS_CMP |-> $past(state_q) == S_INS_RD)
		else $error("compare step without a preceding read");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_ld |-> (!rsp_valid_q || !rsp_stall))
		else $error("result loaded over an untaken result");

	a_one_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_ld |=> state_q == S_IDLE && !cmd.out_ld)
		else $error("result loaded twice for one item");

endmodule

`default_nettype wire

// ----- design/sorted_priority_list.sv -----
// Sorted priority list: keeps up to DEPTH signed values in ascending order
// in a two-port memory (one read, one write a cycle, registered read).
// Insert places the value after all stored values less than or equal to it,
// remove returns the largest value, read returns the value at a position
// counted from the smallest; every item gives one result with status and
// count. One item is in work at a time. An insert reads the entry below its
// pointer and, while that entry is greater, moves it up one place and steps
// the pointer down; each move is a read then a compare-and-write of the
// memory, until the bottom or an entry not greater than the value is reached.
// No clearing pass after reset; the block takes items at once.
// Depends on spl_pkg, spl_ctrl and spl_dp.
`timescale 1ns / 1ps
`default_nettype none

module sorted_priority_list
	import spl_pkg::*;
#(
	parameter int DEPTH      = DEPTH_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF,
	localparam int AW        = $clog2(DEPTH),
	localparam int CW        = $clog2(DEPTH + 1)
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               req_valid,
	output logic                    req_stall,
	input  wire logic [1:0]         req_type,
	input  wire logic signed [31:0] value,
	input  wire logic [AW-1:0]      index,
	output logic                    rsp_valid,
	input  wire logic               rsp_stall,
	output logic [1:0]              status,
	output logic signed [31:0]      data_out,
	output logic [CW-1:0]           count
);

	spl_cmd_t  cmd;
	spl_stat_t stat;

	spl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	spl_dp #(
		.DEPTH      (DEPTH),
		.VALUE_BITS (VALUE_BITS),
		.AW         (AW),
		.CW         (CW)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.req_type (req_type),
		.value    (value),
		.index    (index),
		.status   (status),
		.data_out (data_out),
		.count    (count)
	);

endmodule

`default_nettype wire

// ----- bench/spl_checker.sv -----
// spl_checker: watches both channels of sorted_priority_list, predicts each result
// from its own copy of the sorted list and compares field by field.
// depends on spl_pkg
`timescale 1ns / 1ps

module spl_checker
	import spl_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               req_valid,
	input  wire logic               req_stall,
	input  wire logic [1:0]         req_type,
	input  wire logic signed [31:0] value,
	input  wire logic [4:0]         index,
	input  wire logic               rsp_valid,
	input  wire logic               rsp_stall,
	input  wire logic [1:0]         status,
	input  wire logic signed [31:0] data_out,
	input  wire logic [5:0]         count,
	output int                      errors,
	output int                      pending,
	output int                      answered,
	output int                      full_seen,
	output int                      empty_seen,
	output int                      range_seen,
	output int                      peak
);

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] data;
		logic [5:0]         cnt;
	} spl_rsp_t;

	logic signed [31:0] sorted_vals [DEPTH];
	int                 fill_lvl     = 0;
	spl_rsp_t           awaited_q [$];
	int                 err_cnt      = 0;
	int                 answered_cnt = 0;
	int                 full_cnt     = 0;
	int                 empty_cnt    = 0;
	int                 range_cnt    = 0;
	int                 peak_lvl     = 0;

	initial begin
		errors     = 0;
		pending    = 0;
		answered   = 0;
		full_seen  = 0;
		empty_seen = 0;
		range_seen = 0;
		peak       = 0;
	end

	// updates the list copy and returns the result the block should give
	function automatic spl_rsp_t apply_request(input logic [1:0] t,
			input logic signed [31:0] v, input logic [4:0] ix);
		spl_rsp_t r;
		int       pos;
		int       j;
		r.status = ST_OK;
		r.data   = '0;
		case (t)
			REQ_INSERT: begin
				if (fill_lvl >= DEPTH) begin
					r.status = ST_FULL;
				end else begin
					// equal values go after the ones already stored
					pos = 0;
					while (pos < fill_lvl && sorted_vals[pos] <= v)
						pos++;
					for (j = fill_lvl; j > pos; j--)
						sorted_vals[j] = sorted_vals[j-1];
					sorted_vals[pos] = v;
					fill_lvl++;
				end
			end
			REQ_REMOVE: begin
				if (fill_lvl == 0) begin
					r.status = ST_EMPTY;
				end else begin
					fill_lvl--;
					r.data = sorted_vals[fill_lvl];
				end
			end
			REQ_READ: begin
				if (int'(ix) >= fill_lvl)
					r.status = ST_RANGE;
				else
					r.data = sorted_vals[ix];
			end
			default: ;
		endcase
		r.cnt = 6'(fill_lvl);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		spl_rsp_t exp_r;
		spl_rsp_t new_r;
		if (!arst_n) begin
			fill_lvl = 0;
			awaited_q.delete();
		end else begin
			if (rsp_valid && !rsp_stall) begin
				answered_cnt++;
				if (awaited_q.size() == 0) begin
					err_cnt++;
					if (err_cnt <= 10)
						$display("[%0t] unexpected result: status %0d data %0d count %0d",
							$realtime, status, data_out, count);
				end else begin
					exp_r = awaited_q.pop_front();
					if (status !== exp_r.status || data_out !== exp_r.data ||
							count !== exp_r.cnt) begin
						err_cnt++;
						if (err_cnt <= 10)
							$display("[%0t] expected st %0d data %0d cnt %0d, got st %0d data %0d cnt %0d",
								$realtime, exp_r.status, exp_r.data, exp_r.cnt,
								status, data_out, count);
					end
				end
			end
			if (req_valid && !req_stall) begin
				new_r = apply_request(req_type, value, index);
				case (new_r.status)
					ST_FULL:  full_cnt++;
					ST_EMPTY: empty_cnt++;
					ST_RANGE: range_cnt++;
					default: ;
				endcase
				awaited_q.push_back(new_r);
				if (fill_lvl > peak_lvl)
					peak_lvl = fill_lvl;
			end
		end
		errors     <= err_cnt;
		pending    <= awaited_q.size();
		answered   <= answered_cnt;
		full_seen  <= full_cnt;
		empty_seen <= empty_cnt;
		range_seen <= range_cnt;
		peak       <= peak_lvl;
	end

endmodule

// ----- bench/tb_sorted_priority_list.sv -----
// tb_sorted_priority_list: drives requests into sorted_priority_list with random
// idling and stalls, and reports the verdict from the checker's failure and pending counts.
// depends on spl_pkg, sorted_priority_list and spl_checker
`timescale 1ns / 1ps

module tb_sorted_priority_list;
	import spl_pkg::*;

	localparam logic [1:0] REQ_UNUSED  = 2'd3;
	localparam int         RAND_ITEMS  = 1950;
	localparam int         HOLD_CYCLES = 300;
	localparam int         TAIL_CYCLES = 80;
	localparam int         LIMIT       = 4000000;

	typedef enum logic [1:0] {MIX_FILL, MIX_DRAIN, MIX_READ, MIX_ANY} mix_t;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               req_valid = 1'b0;
	logic               req_stall;
	logic [1:0]         req_type  = REQ_INSERT;
	logic signed [31:0] value     = '0;
	logic [4:0]         index     = '0;
	logic               rsp_valid;
	logic               rsp_stall = 1'b0;
	logic [1:0]         status;
	logic signed [31:0] data_out;
	logic [5:0]         count;

	int   errors, pending, answered, full_seen, empty_seen, range_seen, peak;
	int   sent      = 0;
	int   cycles    = 0;
	int   hold_ask  = 0;
	logic calm      = 1'b0;

	always #5 clk = ~clk;

	sorted_priority_list u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_type  (req_type),
		.value     (value),
		.index     (index),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.status    (status),
		.data_out  (data_out),
		.count     (count)
	);

	spl_checker u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req_type   (req_type),
		.value      (value),
		.index      (index),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.status     (status),
		.data_out   (data_out),
		.count      (count),
		.errors     (errors),
		.pending    (pending),
		.answered   (answered),
		.full_seen  (full_seen),
		.empty_seen (empty_seen),
		.range_seen (range_seen),
		.peak       (peak)
	);

	// mostly zero, sometimes a few cycles, rarely a long stretch
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic signed [31:0] pick_value();
		int                 r;
		logic signed [31:0] v;
		r = $urandom_range(0, 9);
		case (r)
			0:       v = 32'sh7fffffff;
			1:       v = 32'sh80000000;
			2, 3:    v = $signed(32'($urandom_range(0, 8))) - 32'sd4;
			4:       v = $signed(32'($urandom_range(0, 15))) <<< 28;
			default: v = $urandom;
		endcase
		return v;
	endfunction

	function automatic logic [4:0] pick_index();
		if ($urandom_range(0, 1) == 0)
			return 5'($urandom_range(0, 7));
		return 5'($urandom_range(0, 31));
	endfunction

	function automatic logic [1:0] pick_req(input mix_t mix);
		int r;
		r = $urandom_range(0, 99);
		case (mix)
			MIX_FILL:  if (r < 80) return REQ_INSERT; else if (r < 90) return REQ_READ;
				else if (r < 97) return REQ_REMOVE;
			MIX_DRAIN: if (r < 15) return REQ_INSERT; else if (r < 70) return REQ_REMOVE;
				else if (r < 95) return REQ_READ;
			MIX_READ:  if (r < 20) return REQ_INSERT; else if (r < 30) return REQ_REMOVE;
				else if (r < 95) return REQ_READ;
			default:   if (r < 40) return REQ_INSERT; else if (r < 70) return REQ_REMOVE;
				else if (r < 95) return REQ_READ;
		endcase
		return REQ_UNUSED;
	endfunction

	// called at a rising edge; returns at the edge where the item is taken
	task automatic offer(input logic [1:0] t, input logic signed [31:0] v,
			input logic [4:0] ix);
		req_valid <= 1'b1;
		req_type  <= t;
		value     <= v;
		index     <= ix;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		sent++;
	endtask

	task automatic idle_for(input int n);
		if (n > 0) begin
			req_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic wait_drain();
		req_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// receiver side: random stall runs, calm stretches, and long holds on request
	initial begin : rsp_side
		int stall_left;
		int hold_left;
		int hold_seen;
		stall_left = 0;
		hold_left  = 0;
		hold_seen  = 0;
		forever begin
			@(posedge clk);
			if (hold_ask != hold_seen) begin
				hold_seen = hold_ask;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				rsp_stall <= 1'b1;
				hold_left--;
			end else if (calm) begin
				rsp_stall <= 1'b0;
			end else if (stall_left > 0) begin
				rsp_stall <= 1'b1;
				stall_left--;
			end else begin
				stall_left = gap_len();
				rsp_stall <= (stall_left > 0);
				if (stall_left > 0)
					stall_left--;
			end
		end
	end

	initial begin : watchdog
		while (cycles < LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("sorted_priority_list: mismatch");
		$finish;
	end

	initial begin : stimulus
		int   directed;
		int   rand_sent;
		int   phase;
		int   n;
		int   k;
		mix_t mix;
		logic quiet;
		logic pressing;
		rand_sent = 0;
		phase     = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty list: remove, read and the unused code
		offer(REQ_REMOVE, $urandom, 5'($urandom));
		offer(REQ_READ, $urandom, 5'd0);
		offer(REQ_UNUSED, $urandom, 5'($urandom));
		// extremes and duplicates, each duplicate goes after its twin
		offer(REQ_INSERT, 32'sd0, 5'd31);
		offer(REQ_INSERT, 32'sh7fffffff, 5'd0);
		idle_for(2);
		offer(REQ_INSERT, 32'sh80000000, 5'd31);
		offer(REQ_INSERT, -32'sd1, 5'd0);
		offer(REQ_INSERT, 32'sd1, 5'd0);
		offer(REQ_INSERT, 32'sh7fffffff, 5'd0);
		offer(REQ_INSERT, 32'sh80000000, 5'd0);
		offer(REQ_INSERT, 32'sd0, 5'd0);
		for (k = 0; k < 8; k++) begin
			offer(REQ_READ, $urandom, 5'(k));
			idle_for(gap_len());
		end
		// index equal to the count and the top index are out of range
		offer(REQ_READ, $urandom, 5'd8);
		offer(REQ_READ, $urandom, 5'd31);
		offer(REQ_UNUSED, $urandom, 5'($urandom));
		offer(REQ_REMOVE, $urandom, 5'($urandom));
		offer(REQ_REMOVE, $urandom, 5'($urandom));
		directed = sent;
		wait_drain();

		while (rand_sent < RAND_ITEMS) begin
			mix      = mix_t'($urandom_range(0, 3));
			n        = $urandom_range(20, 80);
			quiet    = ($urandom_range(0, 4) == 0);
			pressing = (phase == 2 || phase == 17);
			calm <= quiet;
			// long receiver hold while items keep coming, so the input backs up
			if (pressing) begin
				hold_ask <= hold_ask + 1;
				mix = MIX_FILL;
			end
			for (k = 0; k < n; k++) begin
				offer(pick_req(mix), pick_value(), pick_index());
				rand_sent++;
				if (!quiet && !pressing)
					idle_for(gap_len());
			end
			if (pressing || $urandom_range(0, 3) == 0)
				wait_drain();
			phase++;
		end

		req_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d items (%0d directed), %0d results, list peaked at %0d entries",
			sent, directed, answered, peak);
		$display("rejects: %0d full, %0d empty, %0d out of range; %0d long receiver holds",
			full_seen, empty_seen, range_seen, hold_ask);
		if (errors == 0 && pending == 0)
			$display("sorted_priority_list: match");
		else
			$display("sorted_priority_list: mismatch");
		$finish;
	end

endmodule
